// ===== rtl/slx_pkg.sv =====
// Shared types, token codes and helper functions for the script lexer.
`timescale 1ns / 1ps
package slx_pkg;

    // Saturation caps for offsets and lines.
    localparam int unsigned SOURCE_BYTES = 1048576;
    localparam int unsigned LINE_LIMIT   = 65535;
    localparam logic [19:0] POS_CAP  = (SOURCE_BYTES - 1 > 32'hFFFFF) ? 20'hFFFFF
                                                                    : 20'(SOURCE_BYTES - 1);
    localparam logic [15:0] LINE_CAP = (LINE_LIMIT > 32'hFFFF) ? 16'hFFFF : 16'(LINE_LIMIT);
    localparam int unsigned MAX_TOKS = 4;

    // Token kinds.
    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_RPAREN  = 6'd1;
    localparam logic [5:0] K_LBRACE  = 6'd2;
    localparam logic [5:0] K_RBRACE  = 6'd3;
    localparam logic [5:0] K_COMMA   = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_MINUS   = 6'd6;
    localparam logic [5:0] K_PLUS    = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_SLASH   = 6'd9;
    localparam logic [5:0] K_STAR    = 6'd10;
    localparam logic [5:0] K_BANG    = 6'd11;
    localparam logic [5:0] K_EQUAL   = 6'd13;
    localparam logic [5:0] K_GREATER = 6'd15;
    localparam logic [5:0] K_LESS    = 6'd17;
    localparam logic [5:0] K_IDENT   = 6'd19;
    localparam logic [5:0] K_STRING  = 6'd20;
    localparam logic [5:0] K_NUMBER  = 6'd21;
    localparam logic [5:0] K_KW_BASE = 6'd22;
    localparam logic [5:0] K_END     = 6'd38;
    localparam logic [5:0] K_ERROR   = 6'd39;

    // Scanner modes.
    typedef enum logic [3:0] {
        S_IDLE, S_OP, S_SLASH, S_COMMENT, S_STR, S_IDENT, S_INT, S_INTDOT, S_FRAC
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] start;
        logic [19:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  bad;
    } t_tok;

    // All tokens produced by one source byte.
    typedef struct packed {
        t_tok [MAX_TOKS-1:0] tok;
        logic [2:0]          cnt;
    } t_bundle;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] c, input logic paired);
        logic [5:0] k;
        k = K_BANG;
        if (c == "=") k = K_EQUAL;
        else if (c == ">") k = K_GREATER;
        else if (c == "<") k = K_LESS;
        return paired ? k + 6'd1 : k;
    endfunction

    function automatic logic [47:0] kw_word(input logic [3:0] i);
        logic [47:0] w;
        unique case (i)
            4'd0:  w = "and";
            4'd1:  w = "class";
            4'd2:  w = "else";
            4'd3:  w = "false";
            4'd4:  w = "fun";
            4'd5:  w = "for";
            4'd6:  w = "if";
            4'd7:  w = "nil";
            4'd8:  w = "or";
            4'd9:  w = "print";
            4'd10: w = "return";
            4'd11: w = "super";
            4'd12: w = "this";
            4'd13: w = "true";
            4'd14: w = "var";
            default: w = "while";
        endcase
        return w;
    endfunction

    // Sixteen parallel compares; a long word is always an identifier.
    function automatic logic [5:0] word_kind(input logic [47:0] ww, input logic too_long);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 15; i >= 0; i--) begin
            if (!too_long && ww == kw_word(4'(i))) k = K_KW_BASE + 6'(i);
        end
        return k;
    endfunction

    function automatic logic [19:0] pos_inc(input logic [19:0] p);
        return (p < POS_CAP) ? p + 20'd1 : p;
    endfunction

    function automatic logic [15:0] col_inc(input logic [15:0] c);
        return (c != 16'hFFFF) ? c + 16'd1 : c;
    endfunction

    function automatic logic [15:0] line_inc(input logic [15:0] l);
        return (l < LINE_CAP) ? l + 16'd1 : l;
    endfunction

    // Append one token to a bundle; extras beyond the bundle size are dropped.
    function automatic t_bundle push_tok(input t_bundle b, input logic [5:0] kind,
                                         input logic [19:0] start, input logic [19:0] len,
                                         input logic [15:0] line, input logic [15:0] col,
                                         input logic [7:0] bad);
        t_bundle r;
        r = b;
        if (b.cnt < 3'(MAX_TOKS)) begin
            r.tok[b.cnt[1:0]] = '{kind: kind, start: start, len: len,
                                   line: line, col: col, bad: bad};
            r.cnt = b.cnt + 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/slx_if.sv =====
// Handshake interfaces for the source byte channel and the token channel.
`timescale 1ns / 1ps
interface slx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_byte;
    modport source (output valid, ch, final_byte, input ready);
    modport sink (input valid, ch, final_byte, output ready);
endinterface

interface slx_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [19:0] lexeme_start;
    logic [19:0] lexeme_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [7:0]  bad_char;
    logic        last_of_run;
    modport source (output valid, token_kind, lexeme_start, lexeme_length, line_number,
                    column_number, bad_char, last_of_run, input ready);
    modport sink (input valid, token_kind, lexeme_start, lexeme_length, line_number,
                  column_number, bad_char, last_of_run, output ready);
endinterface

// ===== rtl/script_lexer_tokenizer_unit.sv =====
// Top level of the streaming script lexer.
//
//  Channel   Dir  Transfer on          Payload
//  i_byte    in   valid && ready       ch, final_byte
//  o_tok     out  valid && ready       token_kind .. last_of_run
//
// One source byte is taken each cycle while the bundle queue has room.
// Each byte yields zero to four tokens; the sender delivers one token per
// cycle while the output is ready.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output fills the two-entry bundle queue, then holds off input.
`timescale 1ns / 1ps
module script_lexer_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slx_byte_if.sink    i_byte,
    slx_tok_if.source   o_tok
);
    import slx_pkg::*;

    t_bundle w_bundle;
    t_bundle w_head;
    logic    w_full;
    logic    w_head_valid;
    logic    w_pop;
    logic    w_accept;

    assign i_byte.ready = !w_full;
    assign w_accept     = i_byte.valid && !w_full;

    slx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_ch         (i_byte.ch),
        .i_final_byte (i_byte.final_byte),
        .o_bundle     (w_bundle)
    );

    slx_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_accept && (w_bundle.cnt != 3'd0)),
        .i_bundle     (w_bundle),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    slx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_tok        (o_tok)
    );

endmodule

// ===== rtl/slx_front.sv =====
// Scanner front end: classifies one accepted byte per cycle into a token bundle.
`timescale 1ns / 1ps
module slx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_ch,
    input  logic              i_final_byte,
    output slx_pkg::t_bundle  o_bundle
);
    import slx_pkg::*;

    t_mode       r_mode, n_mode;
    logic [7:0]  r_pend, n_pend;
    logic [19:0] r_tb, n_tb;
    logic [19:0] r_pos, n_pos;
    logic [15:0] r_line, n_line;
    logic [15:0] r_col, n_col;
    logic [47:0] r_ww, n_ww;
    logic        r_wtl, n_wtl;
    t_bundle     n_b;
    logic        n_do_idle;
    logic [19:0] n_dot_at;

    // Walk the byte through the scanner in the same order as the language rules.
    always_comb begin
        n_mode = r_mode; n_pend = r_pend; n_tb = r_tb; n_pos = r_pos;
        n_line = r_line; n_col = r_col; n_ww = r_ww; n_wtl = r_wtl;
        n_b = '0; n_do_idle = 1'b1; n_dot_at = '0;

        // Finish or extend the token in progress.
        case (r_mode)
            S_OP: begin
                n_mode = S_IDLE;
                if (i_ch == "=") begin
                    n_pos = pos_inc(n_pos); n_col = col_inc(n_col);
                    n_b = push_tok(n_b, op_kind(r_pend, 1'b1), n_tb, n_pos - n_tb,
                                   n_line, n_col, 8'd0);
                    n_do_idle = 1'b0;
                end else begin
                    n_b = push_tok(n_b, op_kind(r_pend, 1'b0), n_tb, n_pos - n_tb,
                                   n_line, n_col, 8'd0);
                end
            end
            S_SLASH: begin
                if (i_ch == "/") begin
                    n_pos = pos_inc(n_pos); n_col = col_inc(n_col);
                    n_mode = S_COMMENT; n_do_idle = 1'b0;
                end else begin
                    n_mode = S_IDLE;
                    n_b = push_tok(n_b, K_SLASH, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                end
            end
            S_COMMENT: begin
                if (i_ch != 8'h0A) begin
                    n_pos = pos_inc(n_pos); n_col = col_inc(n_col); n_do_idle = 1'b0;
                end else begin
                    n_mode = S_IDLE;
                end
            end
            S_STR: begin
                if (i_ch == 8'h0A) n_line = line_inc(n_line);
                n_pos = pos_inc(n_pos); n_col = col_inc(n_col);
                if (i_ch == "\"") begin
                    n_b = push_tok(n_b, K_STRING, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                    n_mode = S_IDLE;
                end
                n_do_idle = 1'b0;
            end
            S_IDENT: begin
                if (is_alpha(i_ch) || is_digit(i_ch)) begin
                    if (n_ww[47:40] != 8'd0) n_wtl = 1'b1;
                    else n_ww = {n_ww[39:0], i_ch};
                    n_pos = pos_inc(n_pos); n_col = col_inc(n_col); n_do_idle = 1'b0;
                end else begin
                    n_mode = S_IDLE;
                    n_b = push_tok(n_b, word_kind(n_ww, n_wtl), n_tb, n_pos - n_tb,
                                   n_line, n_col, 8'd0);
                end
            end
            S_INT, S_FRAC: begin
                if (is_digit(i_ch)) begin
                    n_pos = pos_inc(n_pos); n_col = col_inc(n_col); n_do_idle = 1'b0;
                end else if (i_ch == "." && r_mode == S_INT) begin
                    n_mode = S_INTDOT; n_do_idle = 1'b0;
                end else begin
                    n_mode = S_IDLE;
                    n_b = push_tok(n_b, K_NUMBER, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                end
            end
            S_INTDOT: begin
                if (is_digit(i_ch)) begin
                    n_pos = pos_inc(pos_inc(n_pos)); n_col = col_inc(col_inc(n_col));
                    n_mode = S_FRAC; n_do_idle = 1'b0;
                end else begin
                    n_mode = S_IDLE;
                    n_dot_at = n_pos;
                    n_b = push_tok(n_b, K_NUMBER, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                    n_pos = pos_inc(n_pos); n_col = col_inc(n_col);
                    n_b = push_tok(n_b, K_DOT, n_dot_at, 20'd1, n_line, n_col, 8'd0);
                end
            end
            default: n_mode = S_IDLE;
        endcase

        // Start a new token from the idle state.
        if (n_do_idle) begin
            n_tb = n_pos;
            n_pos = pos_inc(n_pos); n_col = col_inc(n_col);
            case (i_ch)
                "(": n_b = push_tok(n_b, K_LPAREN, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                ")": n_b = push_tok(n_b, K_RPAREN, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                "{": n_b = push_tok(n_b, K_LBRACE, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                "}": n_b = push_tok(n_b, K_RBRACE, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                ",": n_b = push_tok(n_b, K_COMMA, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                ".": n_b = push_tok(n_b, K_DOT, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                "-": n_b = push_tok(n_b, K_MINUS, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                "+": n_b = push_tok(n_b, K_PLUS, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                ";": n_b = push_tok(n_b, K_SEMI, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                "*": n_b = push_tok(n_b, K_STAR, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                "!", "=", "<", ">": begin
                    n_pend = i_ch; n_mode = S_OP;
                end
                "/": n_mode = S_SLASH;
                "\"": n_mode = S_STR;
                " ", 8'h0D, 8'h09: ;
                8'h0A: begin
                    n_col = 16'd1; n_line = line_inc(n_line);
                end
                default: begin
                    if (is_digit(i_ch)) begin
                        n_mode = S_INT;
                    end else if (is_alpha(i_ch)) begin
                        n_ww = {40'd0, i_ch}; n_wtl = 1'b0; n_mode = S_IDENT;
                    end else begin
                        n_b = push_tok(n_b, K_ERROR, n_tb, 20'd1, n_line, n_col, i_ch);
                    end
                end
            endcase
        end

        // End of text: close what is open, send the end token, start over.
        if (i_final_byte) begin
            case (n_mode)
                S_OP: n_b = push_tok(n_b, op_kind(n_pend, 1'b0), n_tb, n_pos - n_tb,
                                     n_line, n_col, 8'd0);
                S_SLASH: n_b = push_tok(n_b, K_SLASH, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                S_IDENT: n_b = push_tok(n_b, word_kind(n_ww, n_wtl), n_tb, n_pos - n_tb,
                                        n_line, n_col, 8'd0);
                S_INT, S_FRAC: n_b = push_tok(n_b, K_NUMBER, n_tb, n_pos - n_tb,
                                              n_line, n_col, 8'd0);
                S_INTDOT: begin
                    n_dot_at = n_pos;
                    n_b = push_tok(n_b, K_NUMBER, n_tb, n_pos - n_tb, n_line, n_col, 8'd0);
                    n_pos = pos_inc(n_pos); n_col = col_inc(n_col);
                    n_b = push_tok(n_b, K_DOT, n_dot_at, 20'd1, n_line, n_col, 8'd0);
                end
                default: ;
            endcase
            n_b = push_tok(n_b, K_END, n_pos, 20'd0, n_line, n_col, 8'd0);
            n_mode = S_IDLE; n_pend = '0; n_tb = '0; n_pos = '0;
            n_line = 16'd1; n_col = '0; n_ww = '0; n_wtl = 1'b0;
        end
    end

    assign o_bundle = n_b;

    // Scanner state advances on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE; r_pend <= '0; r_tb <= '0; r_pos <= '0;
            r_line <= 16'd1; r_col <= '0; r_ww <= '0; r_wtl <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode; r_pend <= n_pend; r_tb <= n_tb; r_pos <= n_pos;
            r_line <= n_line; r_col <= n_col; r_ww <= n_ww; r_wtl <= n_wtl;
        end
    end

endmodule

// ===== rtl/slx_queue.sv =====
// Two-entry queue of token bundles between the scanner and the token sender.
`timescale 1ns / 1ps
module slx_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  slx_pkg::t_bundle  i_bundle,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_head_valid,
    output slx_pkg::t_bundle  o_head
);
    import slx_pkg::*;

    t_bundle    r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_bundle;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0; r_rd <= 1'b0; r_count <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/slx_back.sv =====
// Token sender: unpacks queued bundles, one registered token per ready cycle.
`timescale 1ns / 1ps
module slx_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  slx_pkg::t_bundle  i_head,
    output logic              o_pop,
    slx_tok_if.source         o_tok
);
    import slx_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_tok       r_tok;
    logic       r_last;
    logic       n_load;
    logic       n_is_last;

    assign n_load    = i_head_valid && (!r_valid || o_tok.ready);
    assign n_is_last = ({1'b0, r_idx} == i_head.cnt - 3'd1);
    assign o_pop     = n_load && n_is_last;

    // Output register and position inside the head bundle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_idx <= '0;
        end else begin
            if (n_load) begin
                r_valid <= 1'b1;
                r_idx   <= n_is_last ? 2'd0 : r_idx + 2'd1;
            end else if (o_tok.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_tok  <= i_head.tok[r_idx];
            r_last <= n_is_last;
        end
    end

    assign o_tok.valid         = r_valid;
    assign o_tok.token_kind    = r_tok.kind;
    assign o_tok.lexeme_start  = r_tok.start;
    assign o_tok.lexeme_length = r_tok.len;
    assign o_tok.line_number   = r_tok.line;
    assign o_tok.column_number = r_tok.col;
    assign o_tok.bad_char      = r_tok.bad;
    assign o_tok.last_of_run   = r_last;

`ifndef SYNTH
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (i_head.cnt != 3'd0))
        else $error("queued bundle holds no tokens");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ({1'b0, r_idx} < i_head.cnt))
        else $error("token index beyond bundle");
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_idx == 2'd0))
        else $error("token index left open with empty queue");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_tok.ready) |=> r_valid)
        else $error("stalled token dropped");
`endif

endmodule

// ===== tb/sv/script_lexer_tokenizer_unit_tb.sv =====
// Self-checking testbench for the streaming script lexer.
`timescale 1ns / 1ps
module script_lexer_tokenizer_unit_tb;
    import slx_pkg::*;

    // Scanner states of the local token predictor.
    typedef enum logic [3:0] {
        P_IDLE, P_OP, P_SLASH, P_COMMENT, P_STR, P_IDENT, P_INT, P_INTDOT, P_FRAC
    } t_scan;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] start;
        logic [19:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  bad;
        logic        last;
    } t_token;

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    slx_byte_if byte_ch ();
    slx_tok_if  tok_ch ();

    script_lexer_tokenizer_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_byte (byte_ch.sink),
        .o_tok  (tok_ch.source)
    );

    t_token expected_tokens[$];
    int     mismatch_count;
    int     cycle_count;
    logic   sink_stalls;

    // Predictor state.
    t_scan       scan;
    logic [7:0]  held_op;
    logic [19:0] tok_begin;
    logic [19:0] offset;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic [47:0] word_buf;
    logic        word_long;
    t_token      step_toks[$];

    always #5 i_clk = ~i_clk;

    // Cycle counter with the run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    function automatic logic digit_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alpha_c(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] c, input logic paired);
        logic [5:0] k;
        k = K_BANG;
        if (c == "=") k = K_EQUAL;
        else if (c == ">") k = K_GREATER;
        else if (c == "<") k = K_LESS;
        return paired ? k + 6'd1 : k;
    endfunction

    task automatic add_tok(input logic [5:0] kind, input logic [19:0] start,
                           input logic [19:0] len, input logic [7:0] bad);
        if (step_toks.size() < 4)
            step_toks.insert(step_toks.size(),
                             '{kind, start, len, line_no, col_no, bad, 1'b0});
    endtask

    task automatic add_span(input logic [5:0] kind);
        add_tok(kind, tok_begin, offset - tok_begin, 8'd0);
    endtask

    task automatic advance();
        if (offset < POS_CAP) offset++;
        if (col_no != 16'hFFFF) col_no++;
    endtask

    task automatic bump_line();
        if (line_no < LINE_CAP) line_no++;
    endtask

    task automatic clear_scanner();
        scan = P_IDLE;
        held_op = 0;
        tok_begin = 0;
        offset = 0;
        line_no = 1;
        col_no = 0;
        word_buf = 0;
        word_long = 0;
    endtask

    // Keyword lookup over the sixteen reserved words.
    task automatic close_word();
        logic [5:0] k;
        logic [47:0] kw[16];
        kw = '{"and", "class", "else", "false", "fun", "for", "if", "nil",
               "or", "print", "return", "super", "this", "true", "var", "while"};
        k = K_IDENT;
        if (!word_long)
            for (int i = 15; i >= 0; i--)
                if (word_buf == kw[i]) k = K_KW_BASE + 6'(i);
        add_span(k);
    endtask

    task automatic close_dot_number();
        logic [19:0] dot_at;
        dot_at = offset;
        add_span(K_NUMBER);
        advance();
        add_tok(K_DOT, dot_at, 20'd1, 8'd0);
    endtask

    task automatic scan_from_idle(input logic [7:0] c);
        tok_begin = offset;
        advance();
        case (c)
            "(": add_span(K_LPAREN);
            ")": add_span(K_RPAREN);
            "{": add_span(K_LBRACE);
            "}": add_span(K_RBRACE);
            ",": add_span(K_COMMA);
            ".": add_span(K_DOT);
            "-": add_span(K_MINUS);
            "+": add_span(K_PLUS);
            ";": add_span(K_SEMI);
            "*": add_span(K_STAR);
            "!", "=", "<", ">": begin
                held_op = c;
                scan = P_OP;
            end
            "/": scan = P_SLASH;
            "\"": scan = P_STR;
            " ", 8'h0D, 8'h09: ;
            8'h0A: begin
                col_no = 1;
                bump_line();
            end
            default: begin
                if (digit_c(c)) scan = P_INT;
                else if (alpha_c(c)) begin
                    word_buf = {40'd0, c};
                    word_long = 0;
                    scan = P_IDENT;
                end else add_tok(K_ERROR, tok_begin, 20'd1, c);
            end
        endcase
    endtask

    // Works out every token one source byte causes, then queues them.
    task automatic predict_tokens(input logic [7:0] c, input logic fin);
        logic done;
        step_toks = {};
        done = 0;
        case (scan)
            P_OP: begin
                scan = P_IDLE;
                if (c == "=") begin
                    advance();
                    add_span(pair_kind(held_op, 1'b1));
                    done = 1;
                end else add_span(pair_kind(held_op, 1'b0));
            end
            P_SLASH: begin
                if (c == "/") begin
                    advance();
                    scan = P_COMMENT;
                    done = 1;
                end else begin
                    scan = P_IDLE;
                    add_span(K_SLASH);
                end
            end
            P_COMMENT: begin
                if (c != 8'h0A) begin
                    advance();
                    done = 1;
                end else scan = P_IDLE;
            end
            P_STR: begin
                if (c == 8'h0A) bump_line();
                advance();
                if (c == "\"") begin
                    add_span(K_STRING);
                    scan = P_IDLE;
                end
                done = 1;
            end
            P_IDENT: begin
                if (alpha_c(c) || digit_c(c)) begin
                    if (word_buf[47:40] != 0) word_long = 1;
                    else word_buf = {word_buf[39:0], c};
                    advance();
                    done = 1;
                end else begin
                    scan = P_IDLE;
                    close_word();
                end
            end
            P_INT, P_FRAC: begin
                if (digit_c(c)) begin
                    advance();
                    done = 1;
                end else if (c == "." && scan == P_INT) begin
                    scan = P_INTDOT;
                    done = 1;
                end else begin
                    scan = P_IDLE;
                    add_span(K_NUMBER);
                end
            end
            P_INTDOT: begin
                if (digit_c(c)) begin
                    advance();
                    advance();
                    scan = P_FRAC;
                    done = 1;
                end else begin
                    scan = P_IDLE;
                    close_dot_number();
                end
            end
            default: scan = P_IDLE;
        endcase
        if (!done) scan_from_idle(c);
        // End of text closes any open token and adds the end token.
        if (fin) begin
            case (scan)
                P_OP: add_span(pair_kind(held_op, 1'b0));
                P_SLASH: add_span(K_SLASH);
                P_IDENT: close_word();
                P_INT, P_FRAC: add_span(K_NUMBER);
                P_INTDOT: close_dot_number();
                default: ;
            endcase
            add_tok(K_END, offset, 20'd0, 8'd0);
            clear_scanner();
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) expected_tokens.insert(expected_tokens.size(), step_toks[i]);
    endtask

    // Sends one source byte after a random gap and predicts its tokens.
    task automatic send_byte(input logic [7:0] c, input logic fin);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.ch         <= c;
        byte_ch.final_byte <= fin;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        predict_tokens(c, fin);
    endtask

    task automatic send_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
    endtask

    // Stops sending and waits until every expected token has been seen.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    // Random stall on the token side, drawn per transfer.
    initial begin
        int hold;
        tok_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = sink_stalls ? $urandom_range(0, 3) : 0;
            if (hold > 0) begin
                tok_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            tok_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!tok_ch.valid) @(posedge i_clk);
        end
    end

    // Compares each token transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_token w;
        if (i_rst_n && tok_ch.valid && tok_ch.ready) begin
            if (expected_tokens.size() == 0) begin
                report("unexpected token kind", tok_ch.token_kind, 0);
            end else begin
                w = expected_tokens.pop_front();
                if (tok_ch.token_kind !== w.kind) report("kind", tok_ch.token_kind, w.kind);
                if (tok_ch.lexeme_start !== w.start)
                    report("start", tok_ch.lexeme_start, w.start);
                if (tok_ch.lexeme_length !== w.len)
                    report("length", tok_ch.lexeme_length, w.len);
                if (tok_ch.line_number !== w.line) report("line", tok_ch.line_number, w.line);
                if (tok_ch.column_number !== w.col)
                    report("column", tok_ch.column_number, w.col);
                if (tok_ch.bad_char !== w.bad) report("bad byte", tok_ch.bad_char, w.bad);
                if (tok_ch.last_of_run !== w.last)
                    report("last of run", tok_ch.last_of_run, w.last);
            end
        end
    end

    // Operators, pairs, comments, strings with newlines and unterminated ends.
    task automatic test_operators();
        send_text("(){},.-+;*!!=", 0);
        send_text("= ==<<=>>=/ //c\n\"a\nb\" \"x", 1);
    endtask

    // Keywords, long words, decimals, held dots and error bytes.
    task automatic test_words_numbers();
        send_text("and class else while superb abcdefgh 12.5 7.x 3.", 0);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_text("9.", 1);
    endtask

    // Mostly well-formed snippets with random content, with random noise bytes.
    task automatic test_random();
        string frags[] = '{"var ", "x1", " = ", "42", ".5", "\"s t\"", "// n\n", "\n",
                           "if", "(", ")", "<=", "!=", "print", "return", "this", "true",
                           "nil", "or", "fun", "for", "false", "super", "_Zq9", "{", "}",
                           "/", "*", ";", ".", "> ", "\t", "3.", "1..2"};
        int sent;
        sent = 0;
        while (sent < 200) begin
            if ($urandom_range(0, 4) == 0) begin
                send_byte(8'($urandom), $urandom_range(0, 30) == 0);
                sent++;
            end else begin
                string f;
                f = frags[$urandom_range(0, frags.size() - 1)];
                send_text(f, $urandom_range(0, 20) == 0);
                sent += f.len();
            end
            // Hold the sender until all tokens are out whenever sent lies strictly between 100 and 110.
            if (sent > 100 && sent < 110) wait_drained();
            sink_stalls = $urandom_range(0, 5) != 0;
        end
        send_byte(" ", 1);
    endtask

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        cycle_count = 0;
        mismatch_count = 0;
        sink_stalls = 1;
        byte_ch.valid = 0;
        byte_ch.ch = 0;
        byte_ch.final_byte = 0;
        clear_scanner();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_operators();
        test_words_numbers();
        test_random();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
